// ===== hdl/ibte_pkg.sv =====
// Shared constants, types and register codes for the bitmap tile encoder.
package ibte_pkg;

    localparam int TILE_ROWS        = 4;
    localparam int TILE_COLS        = 4;
    localparam int MAX_BITMAP_WORDS = 16;

    localparam int TILE_WORDS = TILE_ROWS * TILE_COLS;
    localparam int TW_W       = (TILE_WORDS > 1) ? $clog2(TILE_WORDS) : 1;
    localparam int BM_IDX_W   = (MAX_BITMAP_WORDS > 1) ? $clog2(MAX_BITMAP_WORDS) : 1;
    localparam int NBM_W      = $clog2(MAX_BITMAP_WORDS + 1);
    localparam int MAX_ROWS   = 32 * MAX_BITMAP_WORDS;
    localparam int MAX_COLS   = 1024;

    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 25;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_TILES = 2'd0,
        CFG_COL_TILES = 2'd1,
        CFG_FLOAT     = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_TILE = 4'b0010,
        B_BMAP = 4'b0100,
        B_OFFS = 4'b1000
    } back_state_t;

    typedef struct packed {
        logic              emit_tile;
        logic              col_end;
        logic [ADDR_W-1:0] tile_addr;
        logic [ADDR_W-1:0] block_base;
        logic [NBM_W-1:0]  nbm;
        logic [ADDR_W-1:0] length;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ===== hdl/ibte_front.sv =====
// Front end: configuration, word intake, tile buffer, zero test and bitmap.
module ibte_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ibte_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ibte_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              word_valid,
    output logic                              word_stall,
    input  logic [ibte_pkg::WORD_W-1:0]       word,
    input  logic                              hold,
    output logic                              push,
    output ibte_pkg::job_t                    job,
    input  logic [ibte_pkg::TW_W-1:0]         tile_rd_idx,
    output logic [ibte_pkg::WORD_W-1:0]       tile_rd_data,
    input  logic [ibte_pkg::BM_IDX_W-1:0]     bm_rd_idx,
    output logic [ibte_pkg::WORD_W-1:0]       bm_rd_data
);
    import ibte_pkg::*;

    logic [ROW_W-1:0]  row_tiles_reg, row_tiles_next;
    logic [COL_W-1:0]  col_tiles_reg, col_tiles_next;
    logic              float_reg, float_next;
    logic              cfg_hit;

    logic [TW_W-1:0]   wit_reg;
    logic              nz_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  col_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic              bm_clear_reg;

    logic [WORD_W-1:0] tile_buf_reg [TILE_WORDS];
    logic [WORD_W-1:0] bitmap_reg   [MAX_BITMAP_WORDS];

    logic [ROW_W-1:0]  eff_rows;
    logic [COL_W-1:0]  eff_cols;
    logic [ROW_W:0]    rows_up;
    logic [NBM_W-1:0]  nbm;
    logic              accept;
    logic              test_nz;
    logic              nz;
    logic              tile_end;
    logic              row_end;
    logic [ADDR_W-1:0] wp_after;
    logic [COL_W-1:0]  col_inc;
    logic              col_wrap;
    logic [ADDR_W-1:0] new_base;
    logic [BM_IDX_W-1:0] bm_set_idx;

    always_comb
    begin
        row_tiles_next = row_tiles_reg;
        col_tiles_next = col_tiles_reg;
        float_next     = float_reg;
        cfg_hit        = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_TILES:
                begin
                    row_tiles_next = cfg_data[ROW_W-1:0];
                    cfg_hit        = 1'b1;
                end
                CFG_COL_TILES:
                begin
                    col_tiles_next = cfg_data;
                    cfg_hit        = 1'b1;
                end
                CFG_FLOAT:
                begin
                    float_next = cfg_data[0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (row_tiles_next == '0)
            eff_rows = ROW_W'(1);
        else if (row_tiles_next > ROW_W'(MAX_ROWS))
            eff_rows = ROW_W'(MAX_ROWS);
        else
            eff_rows = row_tiles_next;

        if (col_tiles_next == '0)
            eff_cols = COL_W'(1);
        else if (col_tiles_next > COL_W'(MAX_COLS))
            eff_cols = COL_W'(MAX_COLS);
        else
            eff_cols = col_tiles_next;
    end

    assign rows_up = {1'b0, eff_rows} + (ROW_W+1)'(31);
    assign nbm     = NBM_W'(rows_up >> 5);

    assign word_stall = hold | bm_clear_reg;
    assign accept     = word_valid & ~word_stall;
    assign test_nz    = float_reg ? (|word[WORD_W-2:0]) : (|word);
    assign nz         = nz_reg | test_nz;
    assign tile_end   = (wit_reg == TW_W'(TILE_WORDS - 1));
    assign row_end    = (row_reg == eff_rows - ROW_W'(1));
    assign wp_after   = nz ? (wp_reg + ADDR_W'(TILE_WORDS)) : wp_reg;
    assign col_inc    = {1'b0, col_reg} + COL_W'(1);
    assign col_wrap   = (col_inc >= eff_cols);
    assign new_base   = col_wrap ? '0 : wp_after;
    assign bm_set_idx = row_reg[BM_IDX_W+4:5];

    assign push           = accept & tile_end & (nz | row_end);
    assign job.emit_tile  = nz;
    assign job.col_end    = row_end;
    assign job.tile_addr  = wp_reg;
    assign job.block_base = base_reg;
    assign job.nbm        = nbm;
    assign job.length     = wp_after - base_reg;

    assign tile_rd_data = tile_buf_reg[tile_rd_idx];
    assign bm_rd_data   = bitmap_reg[bm_rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_tiles_reg <= ROW_W'(1);
            col_tiles_reg <= COL_W'(1);
            float_reg     <= 1'b0;
            wit_reg       <= '0;
            nz_reg        <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            wp_reg        <= ADDR_W'(2);
            bm_clear_reg  <= 1'b0;
        end
        else if (cfg_hit)
        begin
            row_tiles_reg <= row_tiles_next;
            col_tiles_reg <= col_tiles_next;
            float_reg     <= float_next;
            wit_reg       <= '0;
            nz_reg        <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            wp_reg        <= ADDR_W'(1) + ADDR_W'(nbm);
            bm_clear_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (tile_end)
            begin
                wit_reg <= '0;
                nz_reg  <= 1'b0;
                if (row_end)
                begin
                    row_reg      <= '0;
                    bm_clear_reg <= 1'b1;
                    col_reg      <= col_wrap ? '0 : col_inc[ROW_W-1:0];
                    base_reg     <= new_base;
                    wp_reg       <= new_base + ADDR_W'(1) + ADDR_W'(nbm);
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                    wp_reg  <= wp_after;
                end
            end
            else
            begin
                wit_reg <= wit_reg + TW_W'(1);
                nz_reg  <= nz;
            end
        end
        else if (bm_clear_reg && !hold)
        begin
            bm_clear_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            tile_buf_reg[wit_reg] <= word;
    end

    // the bitmap is cleared on a configuration write, and otherwise only once the sequencer has read it out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BITMAP_WORDS; i++)
                bitmap_reg[i] <= '0;
        end
        else if (cfg_hit || (bm_clear_reg && !hold))
        begin
            for (int i = 0; i < MAX_BITMAP_WORDS; i++)
                bitmap_reg[i] <= '0;
        end
        else if (accept && tile_end && nz)
        begin
            bitmap_reg[bm_set_idx] <= bitmap_reg[bm_set_idx] | (WORD_W'(1) << row_reg[4:0]);
        end
    end

endmodule

// ===== hdl/ibte_queue.sv =====
// Two-entry job queue between the front end and the output sequencer.
module ibte_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  ibte_pkg::job_t            job_in,
    input  logic                      pop,
    output ibte_pkg::job_t            head,
    output ibte_pkg::queue_status_t   status
);
    import ibte_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= job_in;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("job queue underflow");

endmodule

// ===== hdl/ibte_back.sv =====
// Output sequencer: emits tile words, bitmap words and the offset word.
module ibte_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ibte_pkg::job_t                head,
    input  ibte_pkg::queue_status_t       q_status,
    output logic                          pop,
    output logic                          busy,
    output logic [ibte_pkg::TW_W-1:0]     tile_rd_idx,
    input  logic [ibte_pkg::WORD_W-1:0]   tile_rd_data,
    output logic [ibte_pkg::BM_IDX_W-1:0] bm_rd_idx,
    input  logic [ibte_pkg::WORD_W-1:0]   bm_rd_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ibte_pkg::ADDR_W-1:0]   address,
    output logic [ibte_pkg::WORD_W-1:0]   data,
    output logic                          last
);
    import ibte_pkg::*;

    back_state_t       state_reg, state_next;
    job_t              job_reg;
    logic [TW_W-1:0]   tcnt_reg;
    logic [NBM_W-1:0]  bcnt_reg;
    logic              res_valid_reg;
    logic [ADDR_W-1:0] address_reg, address_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic              load;
    logic              emit;
    logic              tile_done;
    logic              bmap_done;

    assign load        = ~res_valid_reg | ~result_stall;
    assign pop         = (state_reg == B_IDLE) & ~q_status.empty;
    assign busy        = (state_reg != B_IDLE);
    assign tile_rd_idx = tcnt_reg;
    assign bm_rd_idx   = bcnt_reg[BM_IDX_W-1:0];
    assign tile_done   = (tcnt_reg == TW_W'(TILE_WORDS - 1));
    assign bmap_done   = (bcnt_reg == job_reg.nbm - NBM_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        emit         = 1'b0;
        address_next = address_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                    state_next = head.emit_tile ? B_TILE : B_BMAP;
            end
            B_TILE:
            begin
                emit         = 1'b1;
                address_next = job_reg.tile_addr + ADDR_W'(tcnt_reg);
                data_next    = tile_rd_data;
                last_next    = tile_done & ~job_reg.col_end;
                if (load && tile_done)
                    state_next = job_reg.col_end ? B_BMAP : B_IDLE;
            end
            B_BMAP:
            begin
                emit         = 1'b1;
                address_next = job_reg.block_base + ADDR_W'(1) + ADDR_W'(bcnt_reg);
                data_next    = bm_rd_data;
                last_next    = 1'b0;
                if (load && bmap_done)
                    state_next = B_OFFS;
            end
            B_OFFS:
            begin
                emit         = 1'b1;
                address_next = job_reg.block_base;
                data_next    = WORD_W'(job_reg.length);
                last_next    = 1'b1;
                if (load)
                    state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            tcnt_reg      <= '0;
            bcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                res_valid_reg <= emit;
            if (pop)
            begin
                tcnt_reg <= '0;
                bcnt_reg <= '0;
            end
            else if (load && state_reg == B_TILE)
                tcnt_reg <= tcnt_reg + TW_W'(1);
            else if (load && state_reg == B_BMAP)
                bcnt_reg <= bcnt_reg + NBM_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        if (load)
        begin
            address_reg <= address_next;
            data_reg    <= data_next;
            last_reg    <= last_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign address      = address_reg;
    assign data         = data_reg;
    assign last         = last_reg;

    a_bmap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_BMAP) |-> (bcnt_reg < job_reg.nbm))
        else $error("bitmap index past bitmap word count");

    a_tile_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_TILE) |-> job_reg.emit_tile)
        else $error("tile drain without a nonzero tile");

endmodule

// ===== hdl/interleaved_bitmap_tile_encoder.sv =====
// Top level of the block-sparse bitmap tile encoder.
// Words arrive one per transfer in tiled order and each 4x4 tile is tested for all-zero
// (in float mode the sign bit is ignored). The intake takes one word per cycle while no
// output job is pending and no bitmap clear is due. The transfer that completes a nonzero
// tile or the last tile of a column queues a job, and the output sequencer then drains
// a nonzero tile from the tile buffer at one word per cycle while the output is not
// stalled, with intake held meanwhile. A column block end adds the bitmap and offset words.
// Every emitted word goes through an output register, and the last result of each
// job carries last. A configuration write restarts the matrix at address zero.
module interleaved_bitmap_tile_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ibte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ibte_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            word_valid,
    output logic                            word_stall,
    input  logic [ibte_pkg::WORD_W-1:0]     word,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [ibte_pkg::ADDR_W-1:0]     address,
    output logic [ibte_pkg::WORD_W-1:0]     data,
    output logic                            last
);
    import ibte_pkg::*;

    logic                push;
    job_t                job;
    job_t                head;
    logic                pop;
    logic                busy;
    queue_status_t       q_status;
    logic [TW_W-1:0]     tile_rd_idx;
    logic [WORD_W-1:0]   tile_rd_data;
    logic [BM_IDX_W-1:0] bm_rd_idx;
    logic [WORD_W-1:0]   bm_rd_data;
    logic                hold;

    assign hold = busy | ~q_status.empty;

    ibte_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word         (word),
        .hold         (hold),
        .push         (push),
        .job          (job),
        .tile_rd_idx  (tile_rd_idx),
        .tile_rd_data (tile_rd_data),
        .bm_rd_idx    (bm_rd_idx),
        .bm_rd_data   (bm_rd_data)
    );

    ibte_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    ibte_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .busy         (busy),
        .tile_rd_idx  (tile_rd_idx),
        .tile_rd_data (tile_rd_data),
        .bm_rd_idx    (bm_rd_idx),
        .bm_rd_data   (bm_rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .address      (address),
        .data         (data),
        .last         (last)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the interleaved bitmap tile encoder.
`timescale 1ns / 100ps

module tb;
    import ibte_pkg::*;

    localparam int RANDOM_WORDS  = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 50;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
        logic              last;
    } enc_word_t;

    typedef enum {
        TK_ZERO,
        TK_SIGNED_ZERO,
        TK_SPARSE,
        TK_DENSE
    } tile_kind_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_ROW_TILES;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  word_valid   = 1'b0;
    logic                  word_stall;
    logic [WORD_W-1:0]     word         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [ADDR_W-1:0]     address;
    logic [WORD_W-1:0]     data;
    logic                  last;

    // stimulus control
    logic        gap_on    = 1'b1;
    logic        stall_on  = 1'b1;
    logic        hold_req  = 1'b0;
    int unsigned hold_count = 0;
    int unsigned words_sent = 0;
    int unsigned error_count = 0;

    // encoder state as predicted
    logic [9:0]        row_reg;
    logic [10:0]       col_reg;
    logic              fp_mode;
    logic [WORD_W-1:0] tile_buf [TILE_WORDS];
    logic [WORD_W-1:0] tile_map [MAX_BITMAP_WORDS];
    int unsigned       tile_pos;
    logic              tile_dirty;
    int unsigned       tile_row;
    int unsigned       col_idx;
    logic [ADDR_W-1:0] blk_base;
    logic [ADDR_W-1:0] wr_ptr;

    enc_word_t encoded_q [$];
    enc_word_t want;

    interleaved_bitmap_tile_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .word_valid   (word_valid),
        .word_stall   (word_stall),
        .word         (word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .address      (address),
        .data         (data),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    function automatic int unsigned rows_used();
        int unsigned r;
        r = row_reg;
        if (r < 1) r = 1;
        if (r > MAX_ROWS) r = MAX_ROWS;
        return r;
    endfunction

    function automatic int unsigned cols_used();
        int unsigned c;
        c = col_reg;
        if (c < 1) c = 1;
        if (c > MAX_COLS) c = MAX_COLS;
        return c;
    endfunction

    function automatic int unsigned bitmap_len();
        return (rows_used() + 31) / 32;
    endfunction

    function automatic void restart_matrix();
        for (int k = 0; k < MAX_BITMAP_WORDS; k++)
            tile_map[k] = '0;
        tile_pos   = 0;
        tile_dirty = 1'b0;
        tile_row   = 0;
        col_idx    = 0;
        blk_base   = '0;
        wr_ptr     = ADDR_W'(1 + bitmap_len());
    endfunction

    function automatic void apply_config(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ROW_TILES: row_reg = val[9:0];
            CFG_COL_TILES: col_reg = val;
            CFG_FLOAT:     fp_mode = val[0];
            default:       return;
        endcase
        restart_matrix();
    endfunction

    function automatic void put_result(input logic [ADDR_W-1:0] a, input logic [WORD_W-1:0] d,
                                       input logic l);
        enc_word_t item;
        item.address = a;
        item.data    = d;
        item.last    = l;
        encoded_q.push_back(item);
    endfunction

    function automatic void encode_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] probe;
        logic [ADDR_W-1:0] span;
        logic              col_end;
        int unsigned       nbm;
        probe = fp_mode ? {1'b0, w[30:0]} : w;
        if (probe != '0)
            tile_dirty = 1'b1;
        tile_buf[tile_pos] = w;
        if (tile_pos < TILE_WORDS - 1)
        begin
            tile_pos++;
            return;
        end
        tile_pos = 0;
        col_end  = (tile_row + 1 >= rows_used());
        if (tile_dirty)
        begin
            for (int k = 0; k < TILE_WORDS; k++)
            begin
                put_result(wr_ptr, tile_buf[k], (k == TILE_WORDS - 1) && !col_end);
                wr_ptr = wr_ptr + 1'b1;
            end
            tile_map[(tile_row / 32) % MAX_BITMAP_WORDS][tile_row % 32] = 1'b1;
        end
        tile_dirty = 1'b0;
        tile_row++;
        if (col_end)
        begin
            nbm = bitmap_len();
            for (int k = 0; k < nbm; k++)
                put_result(ADDR_W'(blk_base + 1 + k), tile_map[k], 1'b0);
            span = wr_ptr - blk_base;
            put_result(blk_base, {{(WORD_W - ADDR_W){1'b0}}, span}, 1'b1);
            for (int k = 0; k < MAX_BITMAP_WORDS; k++)
                tile_map[k] = '0;
            tile_row = 0;
            blk_base = wr_ptr;
            col_idx++;
            if (col_idx >= cols_used())
            begin
                col_idx  = 0;
                blk_base = '0;
            end
            wr_ptr = ADDR_W'(blk_base + 1 + nbm);
        end
    endfunction

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (encoded_q.size() == 0)
                report_error($sformatf("unexpected transfer address %h data %h", address, data));
            else
            begin
                want = encoded_q.pop_front();
                if (address !== want.address)
                    report_error($sformatf("address %h, wanted %h", address, want.address));
                if (data !== want.data)
                    report_error($sformatf("data %h at %h, wanted %h", data, want.address,
                                           want.data));
                if (last !== want.last)
                    report_error($sformatf("last %b at %h, wanted %b", last, want.address,
                                           want.last));
            end
        end
    end

    // output stall: random, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            result_stall <= 1'b1;
            hold_count   <= hold_count + 1;
        end
        else
            result_stall <= stall_on && ($urandom_range(99) < 22);
    end

    task automatic send_word(input logic [WORD_W-1:0] w);
        while (gap_on && $urandom_range(99) < 22)
        begin
            word_valid <= 1'b0;
            @(posedge clk);
        end
        word_valid <= 1'b1;
        word       <= w;
        @(posedge clk);
        while (word_stall)
            @(posedge clk);
        words_sent++;
        encode_word(w);
    endtask

    task automatic settle();
        word_valid <= 1'b0;
        while (encoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        apply_config(idx, val[CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    task automatic set_matrix(input int unsigned rows, input int unsigned cols,
                              input int unsigned fp);
        write_reg(CFG_ROW_TILES, rows);
        write_reg(CFG_COL_TILES, cols);
        write_reg(CFG_FLOAT, fp);
    endtask

    function automatic logic [WORD_W-1:0] rand_nonzero();
        case ($urandom_range(4))
            0:       return 32'h1 << $urandom_range(31);
            1:       return 32'hFFFF_FFFF;
            2:       return {$urandom_range(1) == 1, 31'h7FC0_0000};
            default: return $urandom;
        endcase
    endfunction

    function automatic tile_kind_t random_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return TK_ZERO;
        if (r < 45) return TK_SIGNED_ZERO;
        if (r < 70) return TK_SPARSE;
        return TK_DENSE;
    endfunction

    task automatic send_tile(input tile_kind_t kind);
        int unsigned       hot;
        logic [WORD_W-1:0] w;
        hot = $urandom_range(TILE_WORDS - 1);
        for (int k = 0; k < TILE_WORDS; k++)
        begin
            case (kind)
                TK_ZERO:        w = '0;
                TK_SIGNED_ZERO: w = {$urandom_range(1) == 1, 31'h0};
                TK_SPARSE:      w = (k == hot) ? rand_nonzero() : {$urandom_range(3) == 0, 31'h0};
                default:        w = rand_nonzero();
            endcase
            send_word(w);
        end
    endtask

    task automatic test_reset_state();
        send_tile(TK_ZERO);
        repeat (TILE_WORDS) send_word(32'h8000_0000);
    endtask

    task automatic test_zero_detect();
        write_reg(CFG_FLOAT, 1);
        repeat (TILE_WORDS) send_word(32'h8000_0000);
        for (int k = 0; k < TILE_WORDS; k++)
            send_word((k == 7) ? 32'hFFC0_0000 : 32'h0);
        for (int k = 0; k < TILE_WORDS; k++)
            send_word((k == TILE_WORDS - 1) ? 32'h0000_0001 : 32'h8000_0000);
        write_reg(CFG_FLOAT, 0);
    endtask

    task automatic test_config_restart();
        set_matrix(3, 2, 0);
        repeat (5) send_word(32'h0000_00A5);
        write_reg(CFG_COL_TILES, 2);
        send_tile(random_kind());
        repeat (3) send_word(rand_nonzero());
        write_reg(CFG_ROW_TILES, 11'h400);
        write_reg(CFG_COL_TILES, 0);
        send_tile(TK_DENSE);
    endtask

    task automatic test_output_backpressure();
        set_matrix(4, 3, 0);
        gap_on = 1'b0;
        hold_req <= 1'b1;
        repeat (2) send_tile(TK_DENSE);
        gap_on = 1'b1;
    endtask

    task automatic test_no_idle();
        set_matrix(2, 2, 1);
        gap_on = 1'b0;
        stall_on <= 1'b0;
        repeat (3) send_tile(random_kind());
        settle();
        gap_on = 1'b1;
        stall_on <= 1'b1;
    endtask

    task automatic test_max_rows();
        set_matrix(1023, 1, 1);
        send_tile(TK_DENSE);
    endtask

    task automatic test_max_cols();
        set_matrix(1, 2047, 0);
        repeat (2) send_tile(TK_SPARSE);
    endtask

    task automatic test_random();
        int unsigned start;
        int unsigned rows;
        int unsigned cols;
        int unsigned tiles;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            rows  = ($urandom_range(3) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 6);
            cols  = $urandom_range(1, 3);
            tiles = $urandom_range(1, 2);
            set_matrix(rows, cols, $urandom_range(1));
            repeat (tiles) send_tile(random_kind());
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, TILE_WORDS - 1)) send_word(rand_nonzero());
        end
    endtask

    initial
    begin : main_seq
        int unsigned drain_cycles;
        row_reg = 10'd1;
        col_reg = 11'd1;
        fp_mode = 1'b0;
        restart_matrix();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_detect();
        test_config_restart();
        test_output_backpressure();
        test_no_idle();
        test_max_rows();
        test_max_cols();
        test_random();

        word_valid <= 1'b0;
        drain_cycles = 0;
        while (encoded_q.size() != 0 && drain_cycles < 100_000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (encoded_q.size() != 0)
            report_error($sformatf("%0d results never arrived", encoded_q.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ibte_pkg.sv
hdl/ibte_front.sv
hdl/ibte_queue.sv
hdl/ibte_back.sv
hdl/interleaved_bitmap_tile_encoder.sv
verif/tb.sv
